// ===== design/a64enc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the AArch64 instruction word encoder.
// Depends on nothing; every other file of the block uses it.
package a64enc_pkg;

	localparam int MAX_PATCH_WORDS = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [31:0] NOP_WORD     = 32'hd503201f;
	localparam logic [31:0] BRK_WORD     = 32'hd4200000;
	localparam logic [31:0] SVC_WORD     = 32'hd4000001;
	localparam logic [31:0] RET_WORD     = 32'hd65f03c0;
	localparam logic [31:0] RET_REG_WORD = 32'hd65f0000;
	localparam logic [31:0] BR_WORD      = 32'hd61f0000;
	localparam logic [31:0] BLR_WORD     = 32'hd63f0000;
	localparam logic [31:0] B_WORD       = 32'h14000000;
	localparam logic [31:0] BL_WORD      = 32'h94000000;
	localparam logic [31:0] BCOND_WORD   = 32'h54000000;
	localparam logic [31:0] CBZ_WORD     = 32'h34000000;
	localparam logic [31:0] CBNZ_WORD    = 32'h35000000;
	localparam logic [31:0] TBZ_WORD     = 32'h36000000;
	localparam logic [31:0] TBNZ_WORD    = 32'h37000000;
	localparam logic [31:0] ADDSUB_WORD  = 32'h11000000;

	typedef enum logic [4:0] {
		ACT_NOP     = 5'd0,
		ACT_INT3    = 5'd1,
		ACT_RET     = 5'd2,
		ACT_RET_REG = 5'd3,
		ACT_BRK     = 5'd4,
		ACT_SVC     = 5'd5,
		ACT_BR      = 5'd6,
		ACT_BLR     = 5'd7,
		ACT_B       = 5'd8,
		ACT_BL      = 5'd9,
		ACT_BCOND   = 5'd10,
		ACT_CBZ     = 5'd11,
		ACT_CBNZ    = 5'd12,
		ACT_TBZ     = 5'd13,
		ACT_TBNZ    = 5'd14,
		ACT_ADD     = 5'd15,
		ACT_SUB     = 5'd16,
		ACT_CMP     = 5'd17,
		ACT_MOV_SP  = 5'd18
	} action_t;

	typedef enum logic [1:0] {
		KIND_NUM  = 2'd0,
		KIND_SP   = 2'd1,
		KIND_ZERO = 2'd2
	} reg_kind_t;

	typedef enum logic [3:0] {
		ST_OK           = 4'd0,
		ST_MISALIGNED   = 4'd1,
		ST_BRANCH_RANGE = 4'd2,
		ST_BIT_RANGE    = 4'd3,
		ST_IMM_RANGE    = 4'd4,
		ST_BAD_REG      = 4'd5,
		ST_WIDTH        = 4'd6,
		ST_MOV_FORM     = 4'd7,
		ST_BAD_COND     = 4'd8,
		ST_BAD_LEN      = 4'd9
	} status_t;

	typedef struct packed {
		logic [31:0] word;
		status_t     status;
		logic [4:0]  count;
	} entry_t;

endpackage

// ===== design/a64enc_if.sv =====
`timescale 1ns / 1ps
// Handshake channels of the encoder: request, result and the internal entry channel.
// Depends on a64enc_pkg for the entry type.
interface a64enc_req_if;
	logic        valid;
	logic        ready;
	logic [4:0]  action;
	logic [4:0]  patch_words;
	logic [63:0] branch_address;
	logic [63:0] target_address;
	logic [4:0]  first_reg;
	logic [1:0]  first_kind;
	logic        first_wide;
	logic [4:0]  second_reg;
	logic [1:0]  second_kind;
	logic        second_wide;
	logic [63:0] imm_value;

	modport source(output valid, action, patch_words, branch_address, target_address,
		first_reg, first_kind, first_wide, second_reg, second_kind, second_wide,
		imm_value, input ready);
	modport sink(input valid, action, patch_words, branch_address, target_address,
		first_reg, first_kind, first_wide, second_reg, second_kind, second_wide,
		imm_value, output ready);
endinterface

interface a64enc_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] instr_word;
	logic [3:0]  status;
	logic        last_word;

	modport source(output valid, instr_word, status, last_word, input ready);
	modport sink(input valid, instr_word, status, last_word, output ready);
endinterface

interface a64enc_ent_if;
	logic               valid;
	logic               ready;
	a64enc_pkg::entry_t entry;

	modport source(output valid, entry, input ready);
	modport sink(input valid, entry, output ready);
endinterface

// ===== design/a64enc_front.sv =====
`timescale 1ns / 1ps
// Front end: checks a request and encodes its instruction word into one registered entry.
// Depends on a64enc_pkg and the channel interfaces in a64enc_if.
module a64enc_front #(
	parameter int MAX_PATCH_WORDS = a64enc_pkg::MAX_PATCH_WORDS
) (
	input logic clk,
	input logic arst_n,
	a64enc_req_if.sink request,
	a64enc_ent_if.source entry
);

	typedef struct packed {
		logic       bad;
		logic [4:0] code;
	} reg_res_t;

	typedef struct packed {
		logic        bad;
		logic [31:0] word;
	} imm_res_t;

	function automatic reg_res_t reg_chk(input logic [4:0] num, input logic [1:0] kind,
		input logic sp_ok, input logic zr_ok);
		reg_res_t r;
		r.bad = 1'b1;
		r.code = 5'd31;
		if (kind == a64enc_pkg::KIND_NUM) begin
			r.bad = (num == 5'd31);
			r.code = num;
		end else if (kind == a64enc_pkg::KIND_SP) begin
			r.bad = !sp_ok;
		end else if (kind == a64enc_pkg::KIND_ZERO) begin
			r.bad = !zr_ok;
		end
		return r;
	endfunction

	function automatic imm_res_t addsub(input logic sf, input logic sub, input logic setf,
		input logic [63:0] imm, input logic [4:0] rn, input logic [4:0] rd);
		imm_res_t r;
		logic sh;
		logic [11:0] i12;
		r.bad = 1'b0;
		sh = 1'b0;
		i12 = imm[11:0];
		if (imm[63:12] != '0) begin
			sh = 1'b1;
			i12 = imm[23:12];
			r.bad = (imm[11:0] != '0) || (imm[63:24] != '0);
		end
		r.word = a64enc_pkg::ADDSUB_WORD | {sf, sub, setf, 6'd0, sh, i12, rn, rd};
		return r;
	endfunction

	logic [63:0] delta;
	logic        misaligned;
	logic        far_27;
	logic        far_20;
	logic        far_15;
	logic        len_bad;
	reg_res_t    ra;
	reg_res_t    rb;
	imm_res_t    ai;
	a64enc_pkg::status_t st;
	logic [31:0] word;
	a64enc_pkg::entry_t next_entry;

	logic               valid_s1;
	a64enc_pkg::entry_t entry_s1;
	logic               take;

	assign delta = request.target_address - request.branch_address;
	assign misaligned = (delta[1:0] != 2'b00);
	assign far_27 = !((&delta[63:27]) || !(|delta[63:27]));
	assign far_20 = !((&delta[63:20]) || !(|delta[63:20]));
	assign far_15 = !((&delta[63:15]) || !(|delta[63:15]));
	assign len_bad = (request.patch_words == 5'd0) ||
		(int'(request.patch_words) > MAX_PATCH_WORDS);

	always_comb begin
		st = a64enc_pkg::ST_OK;
		word = '0;
		ra = '0;
		rb = '0;
		ai = '0;
		case (a64enc_pkg::action_t'(request.action))
			a64enc_pkg::ACT_NOP: begin
				word = a64enc_pkg::NOP_WORD;
			end
			a64enc_pkg::ACT_INT3: begin
				word = a64enc_pkg::BRK_WORD;
			end
			a64enc_pkg::ACT_RET: begin
				word = a64enc_pkg::RET_WORD;
			end
			a64enc_pkg::ACT_RET_REG, a64enc_pkg::ACT_BR, a64enc_pkg::ACT_BLR: begin
				ra = reg_chk(request.first_reg, request.first_kind, 1'b0, 1'b0);
				if (ra.bad || !request.first_wide) begin
					st = a64enc_pkg::ST_BAD_REG;
				end else if (request.action == a64enc_pkg::ACT_RET_REG) begin
					word = a64enc_pkg::RET_REG_WORD | {22'd0, ra.code, 5'd0};
				end else if (request.action == a64enc_pkg::ACT_BR) begin
					word = a64enc_pkg::BR_WORD | {22'd0, ra.code, 5'd0};
				end else begin
					word = a64enc_pkg::BLR_WORD | {22'd0, ra.code, 5'd0};
				end
			end
			a64enc_pkg::ACT_BRK, a64enc_pkg::ACT_SVC: begin
				if (request.imm_value[63:16] != '0) begin
					st = a64enc_pkg::ST_IMM_RANGE;
				end else if (request.action == a64enc_pkg::ACT_BRK) begin
					word = a64enc_pkg::BRK_WORD | {11'd0, request.imm_value[15:0], 5'd0};
				end else begin
					word = a64enc_pkg::SVC_WORD | {11'd0, request.imm_value[15:0], 5'd0};
				end
			end
			a64enc_pkg::ACT_B, a64enc_pkg::ACT_BL: begin
				if (misaligned) begin
					st = a64enc_pkg::ST_MISALIGNED;
				end else if (far_27) begin
					st = a64enc_pkg::ST_BRANCH_RANGE;
				end else if (request.action == a64enc_pkg::ACT_BL) begin
					word = a64enc_pkg::BL_WORD | {6'd0, delta[27:2]};
				end else begin
					word = a64enc_pkg::B_WORD | {6'd0, delta[27:2]};
				end
			end
			a64enc_pkg::ACT_BCOND: begin
				if (request.imm_value > 64'd13) begin
					st = a64enc_pkg::ST_BAD_COND;
				end else if (misaligned) begin
					st = a64enc_pkg::ST_MISALIGNED;
				end else if (far_20) begin
					st = a64enc_pkg::ST_BRANCH_RANGE;
				end else begin
					word = a64enc_pkg::BCOND_WORD |
						{8'd0, delta[20:2], 1'b0, request.imm_value[3:0]};
				end
			end
			a64enc_pkg::ACT_CBZ, a64enc_pkg::ACT_CBNZ: begin
				ra = reg_chk(request.first_reg, request.first_kind, 1'b0, 1'b1);
				if (ra.bad) begin
					st = a64enc_pkg::ST_BAD_REG;
				end else if (misaligned) begin
					st = a64enc_pkg::ST_MISALIGNED;
				end else if (far_20) begin
					st = a64enc_pkg::ST_BRANCH_RANGE;
				end else begin
					word = ((request.action == a64enc_pkg::ACT_CBNZ) ?
						a64enc_pkg::CBNZ_WORD : a64enc_pkg::CBZ_WORD) |
						{request.first_wide, 7'd0, delta[20:2], ra.code};
				end
			end
			a64enc_pkg::ACT_TBZ, a64enc_pkg::ACT_TBNZ: begin
				ra = reg_chk(request.first_reg, request.first_kind, 1'b0, 1'b1);
				if (ra.bad) begin
					st = a64enc_pkg::ST_BAD_REG;
				end else if ((request.imm_value[63:6] != '0) ||
					(!request.first_wide && request.imm_value[5])) begin
					st = a64enc_pkg::ST_BIT_RANGE;
				end else if (misaligned) begin
					st = a64enc_pkg::ST_MISALIGNED;
				end else if (far_15) begin
					st = a64enc_pkg::ST_BRANCH_RANGE;
				end else begin
					word = ((request.action == a64enc_pkg::ACT_TBNZ) ?
						a64enc_pkg::TBNZ_WORD : a64enc_pkg::TBZ_WORD) |
						{request.imm_value[5], 7'd0, request.imm_value[4:0], delta[15:2],
						ra.code};
				end
			end
			a64enc_pkg::ACT_ADD, a64enc_pkg::ACT_SUB: begin
				ra = reg_chk(request.first_reg, request.first_kind, 1'b1, 1'b0);
				rb = reg_chk(request.second_reg, request.second_kind, 1'b1, 1'b0);
				ai = addsub(request.first_wide, request.action == a64enc_pkg::ACT_SUB,
					1'b0, request.imm_value, rb.code, ra.code);
				if (ra.bad || rb.bad) begin
					st = a64enc_pkg::ST_BAD_REG;
				end else if (request.first_wide != request.second_wide) begin
					st = a64enc_pkg::ST_WIDTH;
				end else if (ai.bad) begin
					st = a64enc_pkg::ST_IMM_RANGE;
				end else begin
					word = ai.word;
				end
			end
			a64enc_pkg::ACT_CMP: begin
				ra = reg_chk(request.first_reg, request.first_kind, 1'b1, 1'b0);
				ai = addsub(request.first_wide, 1'b1, 1'b1, request.imm_value, ra.code,
					5'd31);
				if (ra.bad) begin
					st = a64enc_pkg::ST_BAD_REG;
				end else if (ai.bad) begin
					st = a64enc_pkg::ST_IMM_RANGE;
				end else begin
					word = ai.word;
				end
			end
			a64enc_pkg::ACT_MOV_SP: begin
				ra = reg_chk(request.first_reg, request.first_kind, 1'b1, 1'b0);
				rb = reg_chk(request.second_reg, request.second_kind, 1'b1, 1'b0);
				if (ra.bad || rb.bad) begin
					st = a64enc_pkg::ST_BAD_REG;
				end else if (!request.first_wide || !request.second_wide ||
					((request.first_kind != a64enc_pkg::KIND_SP) &&
					(request.second_kind != a64enc_pkg::KIND_SP))) begin
					st = a64enc_pkg::ST_MOV_FORM;
				end else begin
					word = a64enc_pkg::ADDSUB_WORD | {1'b1, 21'd0, rb.code, ra.code};
				end
			end
			default: begin
				st = a64enc_pkg::ST_MOV_FORM;
			end
		endcase
	end

	always_comb begin
		next_entry.word = word;
		next_entry.status = st;
		next_entry.count = request.patch_words;
		if (len_bad) begin
			next_entry.status = a64enc_pkg::ST_BAD_LEN;
		end
		if (len_bad || st != a64enc_pkg::ST_OK) begin
			next_entry.word = '0;
			next_entry.count = 5'd1;
		end
	end

	assign request.ready = !valid_s1 || entry.ready;
	assign take = request.valid && request.ready;
	assign entry.valid = valid_s1;
	assign entry.entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (request.ready) begin
			valid_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			entry_s1 <= next_entry;
		end
	end

endmodule

// ===== design/a64enc_queue.sv =====
`timescale 1ns / 1ps
// Short queue of encoded entries between the front and back ends.
// Depends on a64enc_pkg and the entry channel in a64enc_if.
module a64enc_queue (
	input logic clk,
	input logic arst_n,
	a64enc_ent_if.sink push,
	a64enc_ent_if.source pop
);

	localparam int Depth = a64enc_pkg::QUEUE_DEPTH;
	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	a64enc_pkg::entry_t slot_q [Depth];
	logic [PtrW-1:0]    wr_ptr_q;
	logic [PtrW-1:0]    rd_ptr_q;
	logic [CntW-1:0]    fill_q;
	logic               do_push;
	logic               do_pop;

	assign push.ready = (fill_q != CntW'(Depth));
	assign pop.valid = (fill_q != '0);
	assign pop.entry = slot_q[rd_ptr_q];
	assign do_push = push.valid && push.ready;
	assign do_pop = pop.valid && pop.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.entry;
		end
	end

endmodule

// ===== design/a64enc_back.sv =====
`timescale 1ns / 1ps
// Back end: emits each entry's word and then the NOP padding words into the result register.
// Depends on a64enc_pkg and the channels in a64enc_if.
module a64enc_back (
	input logic clk,
	input logic arst_n,
	a64enc_ent_if.sink entry,
	a64enc_rsp_if.source result
);

	logic                out_valid_q;
	logic [31:0]         out_word_q;
	a64enc_pkg::status_t out_status_q;
	logic                out_last_q;
	logic [4:0]          rem_q;
	logic                load;
	logic                padding;

	assign load = !out_valid_q || result.ready;
	assign padding = (rem_q != '0);
	assign entry.ready = load && !padding;

	assign result.valid = out_valid_q;
	assign result.instr_word = out_word_q;
	assign result.status = out_status_q;
	assign result.last_word = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rem_q <= '0;
		end else if (load) begin
			if (padding) begin
				out_valid_q <= 1'b1;
				rem_q <= rem_q - 1'b1;
			end else if (entry.valid) begin
				out_valid_q <= 1'b1;
				rem_q <= entry.entry.count - 1'b1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (padding) begin
				out_word_q <= a64enc_pkg::NOP_WORD;
				out_status_q <= a64enc_pkg::ST_OK;
				out_last_q <= (rem_q == 5'd1);
			end else if (entry.valid) begin
				out_word_q <= entry.entry.word;
				out_status_q <= entry.entry.status;
				out_last_q <= (entry.entry.count == 5'd1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != a64enc_pkg::ST_OK |-> out_last_q && out_word_q == '0)
		else $error("Error word is not a single zero word.");

	assert property (@(posedge clk) disable iff (!arst_n)
		padding |-> !entry.ready)
		else $error("Entry taken while padding is still due.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_last_q && result.ready |=>
		out_valid_q && out_status_q == a64enc_pkg::ST_OK &&
		out_word_q == a64enc_pkg::NOP_WORD)
		else $error("Padding word missing after a word that is not last.");

endmodule

// ===== design/arm64_instruction_word_encoder.sv =====
`timescale 1ns / 1ps
// Top level of the AArch64 instruction word encoder: front end, entry queue and back end.
// Depends on a64enc_pkg, a64enc_if, a64enc_front, a64enc_queue and a64enc_back.
// A request is taken every cycle while the queue has room. It passes the front end's entry
// register, a queue slot and the back end's output register. A patch of n words leaves as n
// result words in a row, one per cycle while result.ready is high, set by the back end's single
// output register. Errors give one zero word with the status and the last word flag set.
module arm64_instruction_word_encoder #(
	parameter int MAX_PATCH_WORDS = a64enc_pkg::MAX_PATCH_WORDS
) (
	input logic clk,
	input logic arst_n,
	a64enc_req_if.sink request,
	a64enc_rsp_if.source result
);

	a64enc_ent_if front_ch ();
	a64enc_ent_if back_ch ();

	a64enc_front #(
		.MAX_PATCH_WORDS(MAX_PATCH_WORDS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.request(request),
		.entry(front_ch)
	);

	a64enc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(front_ch),
		.pop(back_ch)
	);

	a64enc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.entry(back_ch),
		.result(result)
	);

endmodule
